>>> hw/rtl/clipped_rect_palette_remap_unit_defines.svh
// Assertion macros shared by the checker.
`ifndef CLIPPED_RECT_PALETTE_REMAP_UNIT_DEFINES_SVH
`define CLIPPED_RECT_PALETTE_REMAP_UNIT_DEFINES_SVH

// Antecedent in this cycle, consequent in the next one; quiet during reset.
`define CRPR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Plain implication in the same cycle; quiet during reset.
`define CRPR_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Checked through reset as well.
`define CRPR_ASSERT_RESET(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/crpr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package crpr_pkg;

   localparam int COORD_BITS      = 16;
   localparam int COUNT_BITS      = COORD_BITS - 1;
   localparam int PIXEL_BITS      = 8;
   localparam int TABLE_ADDR_BITS = 8;
   localparam int FRAME_ADDR_BITS = 16;
   localparam int CSR_INDEX_BITS  = 2;

   localparam logic [COORD_BITS-1:0] ROW_PIXELS   = 16'd320;
   localparam logic [COORD_BITS-1:0] LEFT_RESET   = 16'd0;
   localparam logic [COORD_BITS-1:0] RIGHT_RESET  = 16'd320;
   localparam logic [COORD_BITS-1:0] TOP_RESET    = 16'd0;

   // operation codes
   localparam logic [1:0] OP_TABLE_WR = 2'd0;
   localparam logic [1:0] OP_PIXEL_WR = 2'd1;
   localparam logic [1:0] OP_PIXEL_RD = 2'd2;
   localparam logic [1:0] OP_RECT     = 2'd3;

   // configuration register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LEFT  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RIGHT = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TOP   = 2'd2;

   typedef struct packed {
      logic [1:0]                 operation;
      logic [TABLE_ADDR_BITS-1:0] table_index;
      logic [FRAME_ADDR_BITS-1:0] pixel_address;
      logic [PIXEL_BITS-1:0]      write_value;
      logic [COORD_BITS-1:0]      rect_x;
      logic [COORD_BITS-1:0]      rect_y;
      logic [COORD_BITS-1:0]      rect_width;
      logic [COORD_BITS-1:0]      rect_height;
   } req_type;

   typedef struct packed {
      logic [PIXEL_BITS-1:0] read_value;
      logic                  status;
   } rsp_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] start;
      logic [COORD_BITS-1:0] extent;
      logic [COORD_BITS-1:0] low;
      logic [COORD_BITS-1:0] high;
      logic                  upper;
   } clip_req_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] start;
      logic [COORD_BITS-1:0] extent;
      logic                  fail;
   } clip_res_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ_WAIT,
      ST_CLIP_LO,
      ST_CLIP_HI,
      ST_BASE,
      ST_PIX_RD,
      ST_PIX_MAP,
      ST_PIX_WR
   } state_type;

endpackage

`default_nettype wire

>>> hw/rtl/crpr_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module crpr_ram
   import crpr_pkg::*;
#(
   parameter int DATA_BITS = PIXEL_BITS,
   parameter int ADDR_BITS = FRAME_ADDR_BITS
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [DATA_BITS-1:0] wr_data,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [DATA_BITS-1:0] rd_data
);

   localparam int DEPTH = 1 << ADDR_BITS;

   logic [DATA_BITS-1:0] mem_ff [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hw/rtl/crpr_clip_step.sv
`timescale 1ns / 1ps
`default_nettype none

// One clip step on a span: the low limit or the exclusive high limit.
module crpr_clip_step
   import crpr_pkg::*;
(
   input  wire clip_req_type cmd,
   output clip_res_type      res
);

   logic [COORD_BITS-1:0] lo_diff;
   logic [COORD_BITS-1:0] lo_ext;
   logic [COORD_BITS-1:0] hi_end;
   logic [COORD_BITS-1:0] hi_diff;
   logic [COORD_BITS-1:0] hi_ext;

   always_comb begin
      lo_diff = cmd.start - cmd.low;
      lo_ext  = cmd.extent + lo_diff;
      hi_end  = cmd.start + cmd.extent;
      hi_diff = hi_end - cmd.high;
      hi_ext  = cmd.extent - hi_diff;

      res.start  = cmd.start;
      res.extent = cmd.extent;
      res.fail   = 1'b0;
      if (!cmd.upper) begin
         // start below the low limit: shorten and move to the limit
         if (lo_diff[COORD_BITS-1]) begin
            res.start  = cmd.low;
            res.extent = lo_ext;
            res.fail   = lo_ext[COORD_BITS-1] || (lo_ext == '0);
         end
      end else begin
         // end at or past the high limit: cut back
         if (!hi_diff[COORD_BITS-1]) begin
            res.extent = hi_ext;
            res.fail   = hi_ext[COORD_BITS-1] || (hi_ext == '0);
         end
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/clipped_rect_palette_remap_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Clipped rectangle palette remap. Start a transaction by raising start while busy is
// low; every transaction gives exactly one result, shown on rsp for a single cycle with
// rsp_valid high. The receiver cannot stall, so sample rsp whenever rsp_valid is high.
// A table or pixel write returns its result in the cycle after it is taken, with busy
// low; a pixel read holds busy in the read-wait state and returns from there. A
// rectangle holds busy through the x and y clip states, an address state and, per
// covered pixel, a frame read, a table lookup and a frame write through the single
// frame store port pair; an empty or clipped-away one gives status 1 from idle or its
// clip state. Write the configuration registers only while busy is low.
module clipped_rect_palette_remap_unit
   import crpr_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire req_type                   req,
   output logic                           rsp_valid,
   output rsp_type                        rsp,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [COORD_BITS-1:0]     csr_wdata
);

   state_type state_ff, state_in;

   // configuration
   logic [COORD_BITS-1:0] left_ff,  left_in;
   logic [COORD_BITS-1:0] right_ff, right_in;
   logic [COORD_BITS-1:0] top_ff,   top_in;

   // rectangle working registers
   logic [COORD_BITS-1:0] x_ff, x_in;
   logic [COORD_BITS-1:0] y_ff, y_in;
   logic [COORD_BITS-1:0] w_ff, w_in;
   logic [COORD_BITS-1:0] h_ff, h_in;
   logic                  axis_y_ff, axis_y_in;
   logic [FRAME_ADDR_BITS-1:0] row_base_ff, row_base_in;
   logic [FRAME_ADDR_BITS-1:0] addr_ff, addr_in;
   logic [COUNT_BITS-1:0]      col_ff, col_in;
   logic [COUNT_BITS-1:0]      row_ff, row_in;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic accept;
   logic rect_empty;
   logic col_last;
   logic row_last;
   logic [FRAME_ADDR_BITS-1:0] base_addr;
   logic [FRAME_ADDR_BITS-1:0] next_row;

   clip_req_type clip_cmd;
   clip_res_type clip_res;

   // memory ports
   logic                       frame_we, frame_re;
   logic [FRAME_ADDR_BITS-1:0] frame_waddr, frame_raddr;
   logic [PIXEL_BITS-1:0]      frame_wdata, frame_rdata;
   logic                       table_we, table_re;
   logic [PIXEL_BITS-1:0]      table_rdata;

   assign accept     = start && (state_ff == ST_IDLE);
   assign rect_empty = req.rect_width[COORD_BITS-1]  || (req.rect_width == '0) ||
                       req.rect_height[COORD_BITS-1] || (req.rect_height == '0);
   assign col_last   = ((COORD_BITS'(col_ff) + 16'd1) == w_ff);
   assign row_last   = ((COORD_BITS'(row_ff) + 16'd1) == h_ff);
   // row start: byte-swapped y plus y*64, then the column
   assign base_addr  = {y_ff[7:0], y_ff[15:8]} + {y_ff[9:0], 6'b0} + x_ff;
   assign next_row   = row_base_ff + ROW_PIXELS;

   // shared clip unit: x span against left/right, then y span against top/right
   assign clip_cmd.start  = axis_y_ff ? y_ff : x_ff;
   assign clip_cmd.extent = axis_y_ff ? h_ff : w_ff;
   assign clip_cmd.low    = axis_y_ff ? top_ff : left_ff;
   assign clip_cmd.high   = right_ff;
   assign clip_cmd.upper  = (state_ff == ST_CLIP_HI);

   crpr_clip_step u_clip (
      .cmd (clip_cmd),
      .res (clip_res)
   );

   crpr_ram #(
      .DATA_BITS (PIXEL_BITS),
      .ADDR_BITS (FRAME_ADDR_BITS)
   ) u_frame (
      .clock   (clock),
      .wr_en   (frame_we),
      .wr_addr (frame_waddr),
      .wr_data (frame_wdata),
      .rd_en   (frame_re),
      .rd_addr (frame_raddr),
      .rd_data (frame_rdata)
   );

   crpr_ram #(
      .DATA_BITS (PIXEL_BITS),
      .ADDR_BITS (TABLE_ADDR_BITS)
   ) u_table (
      .clock   (clock),
      .wr_en   (table_we),
      .wr_addr (req.table_index),
      .wr_data (req.write_value),
      .rd_en   (table_re),
      .rd_addr (frame_rdata),
      .rd_data (table_rdata)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req.operation == OP_PIXEL_RD) begin
                  state_in = ST_READ_WAIT;
               end else if (req.operation == OP_RECT && !rect_empty) begin
                  state_in = ST_CLIP_LO;
               end
            end
         end
         ST_READ_WAIT: state_in = ST_IDLE;
         ST_CLIP_LO: begin
            state_in = clip_res.fail ? ST_IDLE : ST_CLIP_HI;
         end
         ST_CLIP_HI: begin
            if (clip_res.fail) begin
               state_in = ST_IDLE;
            end else begin
               state_in = axis_y_ff ? ST_BASE : ST_CLIP_LO;
            end
         end
         ST_BASE:    state_in = ST_PIX_RD;
         ST_PIX_RD:  state_in = ST_PIX_MAP;
         ST_PIX_MAP: state_in = ST_PIX_WR;
         ST_PIX_WR: begin
            state_in = (col_last && row_last) ? ST_IDLE : ST_PIX_RD;
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      left_in      = left_ff;
      right_in     = right_ff;
      top_in       = top_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      w_in         = w_ff;
      h_in         = h_ff;
      axis_y_in    = axis_y_ff;
      row_base_in  = row_base_ff;
      addr_in      = addr_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;

      frame_we    = 1'b0;
      frame_re    = 1'b0;
      frame_waddr = addr_ff;
      frame_raddr = addr_ff;
      frame_wdata = table_rdata;
      table_we    = 1'b0;
      table_re    = 1'b0;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_LEFT:  left_in  = csr_wdata;
            CSR_RIGHT: right_in = csr_wdata;
            CSR_TOP:   top_in   = csr_wdata;
            default:   ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            frame_waddr = req.pixel_address;
            frame_raddr = req.pixel_address;
            frame_wdata = req.write_value;
            if (accept) begin
               x_in      = req.rect_x;
               y_in      = req.rect_y;
               w_in      = req.rect_width;
               h_in      = req.rect_height;
               axis_y_in = 1'b0;
               case (req.operation)
                  OP_TABLE_WR: begin
                     table_we     = 1'b1;
                     rsp_valid_in = 1'b1;
                  end
                  OP_PIXEL_WR: begin
                     frame_we     = 1'b1;
                     rsp_valid_in = 1'b1;
                  end
                  OP_PIXEL_RD: begin
                     frame_re = 1'b1;
                  end
                  default: begin
                     // empty rectangle: answer at once
                     if (rect_empty) begin
                        rsp_valid_in = 1'b1;
                        rsp_in.status = 1'b1;
                     end
                  end
               endcase
            end
         end
         ST_READ_WAIT: begin
            rsp_valid_in      = 1'b1;
            rsp_in.read_value = frame_rdata;
         end
         ST_CLIP_LO, ST_CLIP_HI: begin
            if (clip_res.fail) begin
               rsp_valid_in  = 1'b1;
               rsp_in.status = 1'b1;
            end else if (axis_y_ff) begin
               y_in = clip_res.start;
               h_in = clip_res.extent;
            end else begin
               x_in = clip_res.start;
               w_in = clip_res.extent;
            end
            // x span done: move on to y
            if (state_ff == ST_CLIP_HI && !axis_y_ff) begin
               axis_y_in = 1'b1;
            end
         end
         ST_BASE: begin
            row_base_in = base_addr;
            addr_in     = base_addr;
            col_in      = '0;
            row_in      = '0;
         end
         ST_PIX_RD: begin
            frame_re = 1'b1;
         end
         ST_PIX_MAP: begin
            table_re = 1'b1;
         end
         ST_PIX_WR: begin
            frame_we = 1'b1;
            if (col_last) begin
               if (row_last) begin
                  rsp_valid_in = 1'b1;
               end else begin
                  row_in      = row_ff + 1'b1;
                  col_in      = '0;
                  row_base_in = next_row;
                  addr_in     = next_row;
               end
            end else begin
               col_in  = col_ff + 1'b1;
               addr_in = addr_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         left_ff      <= LEFT_RESET;
         right_ff     <= RIGHT_RESET;
         top_ff       <= TOP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         left_ff      <= left_in;
         right_ff     <= right_in;
         top_ff       <= top_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: no reset
   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      y_ff        <= y_in;
      w_ff        <= w_in;
      h_ff        <= h_in;
      axis_y_ff   <= axis_y_in;
      row_base_ff <= row_base_in;
      addr_ff     <= addr_in;
      col_ff      <= col_in;
      row_ff      <= row_in;
      rsp_ff      <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

`default_nettype wire

>>> hw/rtl/crpr_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "clipped_rect_palette_remap_unit_defines.svh"

module crpr_checker
   import crpr_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    start,
   input wire logic    busy,
   input wire req_type req,
   input wire logic    rsp_valid,
   input wire rsp_type rsp,
   input wire logic    csr_valid,
   input wire logic    csr_ready
);

   logic take_write;
   logic take_read;

   assign take_write = start && !busy &&
                       (req.operation == OP_TABLE_WR || req.operation == OP_PIXEL_WR);
   assign take_read  = start && !busy && (req.operation == OP_PIXEL_RD);

   `CRPR_ASSERT_RESET(a_reset_quiet, clock, reset, !busy && !rsp_valid, "not idle after reset")
   `CRPR_ASSERT_NEXT(a_write_answers, clock, reset, take_write, rsp_valid && !busy, "write result missing")
   `CRPR_ASSERT_NEXT(a_read_answers, clock, reset, take_read, busy && !rsp_valid ##1 rsp_valid && !busy, "read result timing")
   `CRPR_ASSERT_NOW(a_status_clean, clock, reset, rsp_valid && rsp.status, rsp.read_value == '0, "status with data")
   `CRPR_ASSERT_NOW(a_csr_idle, clock, reset, csr_valid && csr_ready, !busy, "limit written while busy")

endmodule

bind clipped_rect_palette_remap_unit crpr_checker u_crpr_checker (.*);

`default_nettype wire

>>> tb/clipped_rect_palette_remap_unit_test.sv
`timescale 1ns / 1ps

// Self-checking bench for the clipped rectangle palette remap unit.
module clipped_rect_palette_remap_unit_test;
   import crpr_pkg::*;

   // Clipped span of one rectangle: columns and rows after both limits.
   typedef struct packed {
      logic         empty;
      clip_res_type col;
      clip_res_type row;
   } window_type;

   // ---------------------------------------------------------------
   // Block ports. Every input starts at a known value.
   // ---------------------------------------------------------------
   logic                      clock     = 1'b0;
   logic                      reset     = 1'b1;
   logic                      start     = 1'b0;
   logic                      busy;
   req_type                   req       = '0;
   logic                      rsp_valid;
   rsp_type                   rsp;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_LEFT;
   logic [COORD_BITS-1:0]     csr_wdata = '0;

   // ---------------------------------------------------------------
   // Shadow of the block: limits, remap table and frame store, plus
   // which entries hold a written value (unwritten ones are never read).
   // ---------------------------------------------------------------
   logic [COORD_BITS-1:0]      lim_left  = LEFT_RESET;
   logic [COORD_BITS-1:0]      lim_right = RIGHT_RESET;
   logic [COORD_BITS-1:0]      lim_top   = TOP_RESET;
   logic [PIXEL_BITS-1:0]      lut_copy [256];
   logic [PIXEL_BITS-1:0]      frame_mem [65536];
   bit                         table_valid [256];
   bit                         pixel_valid [65536];
   logic [FRAME_ADDR_BITS-1:0] written_pixels [$];

   // Results predicted at acceptance, oldest first.
   rsp_type awaited_rsp [$];

   int sender_idle_pct = 19;
   int mismatch_count  = 0;
   int results_seen    = 0;
   int table_writes    = 0;
   int pixel_writes    = 0;
   int pixel_reads     = 0;
   int rects_sent      = 0;
   int rects_dropped   = 0;
   int limit_settings  = 0;

   clipped_rect_palette_remap_unit dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp       (rsp),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Hard stop: far beyond the slowest legal run.
   initial begin
      #40_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // ---------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------

   // Clip one axis against a low limit and an exclusive high limit, all in
   // 16-bit two's complement; fail is set when nothing is left.
   function automatic clip_res_type clip_axis(input logic [COORD_BITS-1:0] first,
                                              input logic [COORD_BITS-1:0] span,
                                              input logic [COORD_BITS-1:0] lo,
                                              input logic [COORD_BITS-1:0] hi);
      clip_res_type res;
      logic [COORD_BITS-1:0] over;
      res.start  = first;
      res.extent = span;
      res.fail   = 1'b0;
      over = first - lo;
      if ($signed(over) < 0) begin
         res.extent = span + over;
         res.start  = lo;
         if ($signed(res.extent) <= 0) res.fail = 1'b1;
      end
      over = res.start + res.extent - hi;
      if (!res.fail && $signed(over) >= 0) begin
         res.extent = res.extent - over;
         if ($signed(res.extent) <= 0) res.fail = 1'b1;
      end
      return res;
   endfunction

   // Rows clip against the top row and, oddly, against the right limit too.
   function automatic window_type clip_window(input req_type item);
      window_type wdw;
      wdw.col   = clip_axis(item.rect_x, item.rect_width, lim_left, lim_right);
      wdw.row   = clip_axis(item.rect_y, item.rect_height, lim_top, lim_right);
      wdw.empty = $signed(item.rect_width) <= 0 || $signed(item.rect_height) <= 0 ||
                  wdw.col.fail || wdw.row.fail;
      return wdw;
   endfunction

   // Row start is the byte-swapped row plus row*64 plus the column; rows sit
   // ROW_PIXELS apart and every address wraps at 64 KiB.
   function automatic logic [FRAME_ADDR_BITS-1:0] visit_addr(input window_type wdw,
                                                            input int r, input int c);
      logic [FRAME_ADDR_BITS-1:0] base;
      base = {wdw.row.start[7:0], wdw.row.start[15:8]} + (wdw.row.start << 6) +
             wdw.col.start;
      return FRAME_ADDR_BITS'(base + r * int'(ROW_PIXELS) + c);
   endfunction

   function automatic void note_pixel(input logic [FRAME_ADDR_BITS-1:0] addr);
      if (!pixel_valid[addr]) written_pixels.push_back(addr);
      pixel_valid[addr] = 1'b1;
   endfunction

   // Apply one transaction to the shadow and return the result it must give.
   // A byte covered several times is remapped once per visit.
   function automatic rsp_type remap_outcome(input req_type item);
      rsp_type                    res;
      window_type                 wdw;
      logic [FRAME_ADDR_BITS-1:0] a;
      res = '0;
      case (item.operation)
         OP_TABLE_WR: begin
            lut_copy[item.table_index]    = item.write_value;
            table_valid[item.table_index] = 1'b1;
         end
         OP_PIXEL_WR: begin
            frame_mem[item.pixel_address] = item.write_value;
            note_pixel(item.pixel_address);
         end
         OP_PIXEL_RD: res.read_value = frame_mem[item.pixel_address];
         OP_RECT: begin
            wdw = clip_window(item);
            if (wdw.empty) begin
               res.status = 1'b1;
               rects_dropped++;
            end else begin
               for (int r = 0; r < int'(wdw.row.extent); r++)
                  for (int c = 0; c < int'(wdw.col.extent); c++) begin
                     a = visit_addr(wdw, r, c);
                     frame_mem[a] = lut_copy[frame_mem[a]];
                  end
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   // ---------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------

   // Fill every field at random so unused fields toggle too.
   function automatic req_type noise_item(input logic [1:0] op);
      req_type item;
      item.operation     = op;
      item.table_index   = TABLE_ADDR_BITS'($urandom());
      item.pixel_address = FRAME_ADDR_BITS'($urandom());
      item.write_value   = PIXEL_BITS'($urandom());
      item.rect_x        = COORD_BITS'($urandom());
      item.rect_y        = COORD_BITS'($urandom());
      item.rect_width    = COORD_BITS'($urandom());
      item.rect_height   = COORD_BITS'($urandom());
      return item;
   endfunction

   // Send one transaction: idle first at the current rate, then hold start
   // until the block takes it, and predict its result on acceptance.
   task automatic issue(input req_type item);
      int gap;
      gap = 0;
      while ($urandom_range(99) < sender_idle_pct) gap++;
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req   <= item;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      awaited_rsp.push_back(remap_outcome(item));
      case (item.operation)
         OP_TABLE_WR: table_writes++;
         OP_PIXEL_WR: pixel_writes++;
         OP_PIXEL_RD: pixel_reads++;
         default:     rects_sent++;
      endcase
   endtask

   // Before a rectangle: write every covered frame byte not yet written, then
   // every unwritten table entry the remap chain will look up, with random values.
   task automatic seed_rect_sources(input req_type item);
      window_type                 wdw;
      req_type                    fill;
      logic [FRAME_ADDR_BITS-1:0] a;
      logic [PIXEL_BITS-1:0]      v;
      logic [PIXEL_BITS-1:0]      shadow [int];
      wdw = clip_window(item);
      if (wdw.empty) return;
      for (int r = 0; r < int'(wdw.row.extent); r++)
         for (int c = 0; c < int'(wdw.col.extent); c++) begin
            a = visit_addr(wdw, r, c);
            if (!pixel_valid[a]) begin
               fill = noise_item(OP_PIXEL_WR);
               fill.pixel_address = a;
               issue(fill);
            end
         end
      for (int r = 0; r < int'(wdw.row.extent); r++)
         for (int c = 0; c < int'(wdw.col.extent); c++) begin
            a = visit_addr(wdw, r, c);
            v = shadow.exists(a) ? shadow[a] : frame_mem[a];
            if (!table_valid[v]) begin
               fill = noise_item(OP_TABLE_WR);
               fill.table_index = v;
               issue(fill);
            end
            shadow[a] = lut_copy[v];
         end
   endtask

   task automatic send_access(input logic [1:0] op, input logic [7:0] index,
                              input logic [15:0] addr, input logic [7:0] value);
      req_type item;
      item = noise_item(op);
      item.table_index   = index;
      item.pixel_address = addr;
      item.write_value   = value;
      issue(item);
   endtask

   task automatic send_rect(input logic [15:0] x, input logic [15:0] y,
                            input logic [15:0] w, input logic [15:0] h);
      req_type item;
      item = noise_item(OP_RECT);
      item.rect_x      = x;
      item.rect_y      = y;
      item.rect_width  = w;
      item.rect_height = h;
      seed_rect_sources(item);
      issue(item);
   endtask

   // Drop start and hold until every result is back and the block is idle.
   task automatic settle();
      start <= 1'b0;
      do @(posedge clock); while (awaited_rsp.size() != 0 || busy);
   endtask

   // Leave csr_valid high; the caller drops it after the last write.
   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [COORD_BITS-1:0] value);
      csr_index <= index;
      csr_wdata <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_LEFT:  lim_left  = value;
         CSR_RIGHT: lim_right = value;
         CSR_TOP:   lim_top   = value;
         default:   ;
      endcase
   endtask

   // Change all three limits, only once the block has gone quiet.
   task automatic program_limits(input logic [15:0] left, input logic [15:0] right,
                                 input logic [15:0] top);
      settle();
      write_csr(CSR_LEFT, left);
      write_csr(CSR_RIGHT, right);
      write_csr(CSR_TOP, top);
      csr_valid <= 1'b0;
      limit_settings++;
   endtask

   // Rectangles are drawn mostly near the visible corner with small extents;
   // some sit on an edge with a wide random extent, some are wholly random.
   // Anything whose clipped area would be large is drawn again.
   function automatic req_type pick_rect();
      req_type    item;
      window_type wdw;
      do begin
         item = noise_item(OP_RECT);
         case ($urandom_range(3))
            0, 1: begin
               item.rect_x      = lim_left + 16'($urandom_range(7)) - 16'd2;
               item.rect_y      = lim_top + 16'($urandom_range(7)) - 16'd2;
               item.rect_width  = 16'($urandom_range(4));
               item.rect_height = 16'($urandom_range(4));
            end
            2: if ($urandom_range(1) != 0) begin
                  item.rect_x      = lim_right - 16'($urandom_range(1, 3));
                  item.rect_y      = lim_top + 16'($urandom_range(4));
                  item.rect_height = 16'($urandom_range(1, 2));
               end else begin
                  item.rect_x     = lim_left + 16'($urandom_range(4));
                  item.rect_y     = lim_right - 16'($urandom_range(1, 3));
                  item.rect_width = 16'($urandom_range(1, 2));
               end
            default: ;
         endcase
         wdw = clip_window(item);
      end while (!wdw.empty && longint'(wdw.col.extent) * longint'(wdw.row.extent) > 64);
      return item;
   endfunction

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------

   // Extremes of table index, pixel address and byte value.
   task automatic test_table_and_pixel_access();
      send_access(OP_TABLE_WR, 8'h00, 16'h1234, 8'hFF);
      send_access(OP_TABLE_WR, 8'hFF, 16'hEDCB, 8'h00);
      send_access(OP_PIXEL_WR, 8'h5A, 16'h0000, 8'h00);
      send_access(OP_PIXEL_WR, 8'hA5, 16'hFFFF, 8'hFF);
      send_access(OP_PIXEL_RD, 8'h00, 16'h0000, 8'h00);
      send_access(OP_PIXEL_RD, 8'hFF, 16'hFFFF, 8'hFF);
   endtask

   // Zero and negative extents leave everything alone.
   task automatic test_empty_extents();
      send_rect(16'd10, 16'd10, 16'h0000, 16'd4);
      send_rect(16'd10, 16'd10, 16'd4, 16'h0000);
      send_rect(16'd10, 16'd10, 16'h8000, 16'd4);
      send_rect(16'd10, 16'd10, 16'd4, 16'hFFFF);
   endtask

   // Default limits: columns 0..319, rows 0..319 (bottom is the right limit).
   task automatic test_clip_edges();
      send_rect(16'hFFF0, 16'd4, 16'd10, 16'd2);   // gone off the left
      send_rect(16'd320, 16'd4, 16'd5, 16'd2);     // gone off the right
      send_rect(16'hFFFE, 16'd2, 16'd5, 16'd2);    // trimmed on the left
      send_rect(16'd317, 16'd5, 16'd10, 16'd1);    // trimmed on the right
      send_rect(16'd10, 16'd318, 16'd2, 16'd8);    // trimmed at the bottom
      send_rect(16'd10, 16'd320, 16'd2, 16'd3);    // gone off the bottom
      send_rect(16'd3, 16'h0101, 16'd4, 16'd1);    // both row bytes feed the swap
   endtask

   task automatic test_top_row_clip();
      program_limits(16'd0, 16'd320, 16'd100);
      send_rect(16'd5, 16'd98, 16'd3, 16'd4);      // trimmed at the top
      send_rect(16'd5, 16'd90, 16'd3, 16'd5);      // gone off the top
   endtask

   // Widest window: a rectangle that runs past the end of the frame store
   // and whose rows, one byte wider than a row pitch, share a byte.
   task automatic test_wrap_and_overlap();
      program_limits(16'h8000, 16'h7FFF, 16'h0000);
      send_rect(16'hFF00, 16'd0, 16'd321, 16'd2);
      send_access(OP_PIXEL_RD, 8'h00, 16'h0040, 8'h00);
      send_access(OP_PIXEL_RD, 8'h00, 16'hFFFF, 8'h00);
   endtask

   task automatic test_random_traffic(input int count);
      req_type item;
      int      pick;
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 15) begin
            issue(noise_item(OP_TABLE_WR));
         end else if (pick < 35 || written_pixels.size() == 0) begin
            issue(noise_item(OP_PIXEL_WR));
         end else if (pick < 55) begin
            item = noise_item(OP_PIXEL_RD);
            item.pixel_address = written_pixels[$urandom_range(written_pixels.size() - 1)];
            issue(item);
         end else begin
            item = pick_rect();
            seed_rect_sources(item);
            issue(item);
         end
      end
   endtask

   // Random traffic under a series of limit settings, extremes included,
   // with the sender idling 19%, then 76%, then not at all.
   task automatic test_limit_settings();
      sender_idle_pct = 19;
      program_limits(LEFT_RESET, RIGHT_RESET, TOP_RESET);
      test_random_traffic(30);
      program_limits(16'h8000, 16'h7FFF, 16'h0000);
      test_random_traffic(30);
      sender_idle_pct = 76;
      program_limits(16'd40, 16'd120, 16'd30);
      test_random_traffic(15);
      settle();                                    // let the block run dry mid-phase
      test_random_traffic(15);
      program_limits(16'h7FFF, 16'h8000, 16'hFFFF);
      test_random_traffic(25);
      sender_idle_pct = 0;
      program_limits(16'hFFF0, 16'd64, 16'hFFFE);
      test_random_traffic(25);
      program_limits(16'h0100, 16'h0180, 16'h0100);
      test_random_traffic(20);
   endtask

   // ---------------------------------------------------------------
   // Result checking: each strobed result against the oldest prediction.
   // ---------------------------------------------------------------
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid) begin
         results_seen++;
         if (awaited_rsp.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: unexpected result read_value=%02h status=%0d",
                        $realtime, rsp.read_value, rsp.status);
         end else begin
            want = awaited_rsp.pop_front();
            if (rsp.read_value !== want.read_value || rsp.status !== want.status) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"%0t: result mismatch: expected read_value=%02h status=%0d,",
                            " got read_value=%02h status=%0d"},
                           $realtime, want.read_value, want.status,
                           rsp.read_value, rsp.status);
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Sequence: reset once, directed cases, random phases, drain, verdict.
   // ---------------------------------------------------------------
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_table_and_pixel_access();
      test_empty_extents();
      test_clip_edges();
      test_top_row_clip();
      test_wrap_and_overlap();
      test_limit_settings();

      // Hold until the last result is in, then give stragglers a chance.
      settle();
      repeat (16) @(posedge clock);
      mismatch_count += awaited_rsp.size();

      $display({"Covered %0d transactions: %0d table writes, %0d pixel writes,",
                " %0d pixel reads, %0d rectangles (%0d empty or clipped away)."},
               table_writes + pixel_writes + pixel_reads + rects_sent, table_writes,
               pixel_writes, pixel_reads, rects_sent, rects_dropped);
      $display("Used %0d limit settings; %0d results checked, %0d mismatches.",
               limit_settings, results_seen, mismatch_count);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/crpr_pkg.sv
hw/rtl/crpr_ram.sv
hw/rtl/crpr_clip_step.sv
hw/rtl/clipped_rect_palette_remap_unit.sv
hw/rtl/crpr_checker.sv
tb/clipped_rect_palette_remap_unit_test.sv
